FILE: rtl/button_gesture_detector_top_macros.svh
// ----------------------------------------------------------------------------
// button_gesture_detector_top_macros.svh
// Assertion macros shared by the gesture detector RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_TOP_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BGE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bge_pkg
// Types, widths and codes of the button gesture detector.
// ----------------------------------------------------------------------------
package bge_pkg;

    localparam int BUTTON_COUNT = 32;
    localparam int BTN_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    localparam int OP_W         = 2;
    localparam int BTN_FIELD_W  = 8;
    localparam int TIME_W       = 32;
    localparam int TAP_W        = 8;
    localparam int CNT_W        = $clog2(TIME_W);
    localparam int CFG_IDX_W    = 1;

    localparam logic [BTN_FIELD_W:0] BUTTON_LIMIT = (BTN_FIELD_W+1)'(BUTTON_COUNT);

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [TAP_W-1:0]     t_taps;
    typedef logic [BTN_W-1:0]     t_btn_idx;

    localparam t_op OP_PRESS   = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_POLL    = 2'd2;
    localparam t_op OP_ACK     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP = 1'd1;

    localparam t_time LONG_PRESS_RST = 32'd500;
    localparam t_time DOUBLE_TAP_RST = 32'd300;

    localparam t_taps TAPS_DOUBLE = 8'd2;

endpackage

FILE: rtl/bge_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bge_ifs
// Valid/ready channels carrying gesture detector items and results.
// ----------------------------------------------------------------------------
interface bge_in_if import bge_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_op                    operation;
    logic [BTN_FIELD_W-1:0] button;
    t_time                  event_time;
    t_time                  duration_override;
    t_time                  window_override;
    logic                   ack_long;
    logic                   ack_taps;

    modport source (
        output valid, operation, button, event_time, duration_override,
               window_override, ack_long, ack_taps,
        input  ready
    );
    modport sink (
        input  valid, operation, button, event_time, duration_override,
               window_override, ack_long, ack_taps,
        output ready
    );
endinterface

interface bge_out_if import bge_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  button_ok;
    logic  pressed;
    logic  long_press;
    logic  double_tap;
    t_taps tap_count;

    modport source (
        output valid, button_ok, pressed, long_press, double_tap, tap_count,
        input  ready
    );
    modport sink (
        input  valid, button_ok, pressed, long_press, double_tap, tap_count,
        output ready
    );
endinterface

FILE: rtl/button_gesture_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// Per-button press, long-press and double-tap tracker.
// ----------------------------------------------------------------------------
// One transaction at a time: an accepted item passes through the read state
// (stamp memory read) and the shift state to the done state, where its result
// is registered and the per-button state updated once the output register is
// free; a new item can be accepted in the cycle after the result is registered.
// In the shift state the bit-serial subtract-and-compare unit handles the
// 32-bit elapsed-time checks one bit per cycle, LSB first. An item for a
// button out of range skips the read and shift states and goes straight to
// the done state. A result waits in the output register while
// the next item is accepted and processed.
// ----------------------------------------------------------------------------
`include "button_gesture_detector_top_macros.svh"

module button_gesture_detector_top import bge_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bge_in_if.sink               i_in,
    bge_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_time                i_cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

    // configuration
    t_time r_long_ms;
    t_time r_dtap_ms;

    // per-button state
    logic  r_held  [BUTTON_COUNT];
    logic  r_fired [BUTTON_COUNT];
    t_taps r_taps  [BUTTON_COUNT];
    logic  r_ps_vld[BUTTON_COUNT];
    logic  r_rs_vld[BUTTON_COUNT];
    t_time r_ps_mem[BUTTON_COUNT];
    t_time r_rs_mem[BUTTON_COUNT];

    // control and transaction registers
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    t_op              r_op;
    t_btn_idx         r_idx;
    logic             r_bad;
    logic             r_ack_long;
    logic             r_ack_taps;
    t_time            r_ps_rd, r_rs_rd;
    logic             r_ps_rd_vld, r_rs_rd_vld;

    // serial datapath
    t_time r_t_sh, r_ps_sh, r_rs_sh, r_dur_sh, r_thr_sh;
    logic  r_b1, r_b2, r_lt1, r_lt2;

    // output register
    logic  r_out_valid;
    logic  r_out_ok, r_out_pressed, r_out_lp, r_out_dt;
    t_taps r_out_taps;

    logic     accept;
    logic     in_ok;
    t_btn_idx in_idx;
    logic     out_free;
    logic     commit;
    logic     d1, d2, n_b1, n_b2, n_lt1, n_lt2;
    logic     cur_held, cur_fired;
    t_taps    cur_taps;
    logic     n_held_b, n_fired_b;
    t_taps    n_taps_b;
    logic     n_lp, n_dt;

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid & i_in.ready;
    assign in_ok      = ({1'b0, i_in.button} < BUTTON_LIMIT);
    assign in_idx     = i_in.button[BTN_W-1:0];
    assign out_free   = !r_out_valid | o_out.ready;
    assign commit     = (r_state == ST_DONE) & out_free;

    // bit-serial subtract t - stamp and compare against threshold, LSB first
    assign d1    = r_t_sh[0] ^ r_ps_sh[0] ^ r_b1;
    assign n_b1  = (~r_t_sh[0] & r_ps_sh[0]) | (~(r_t_sh[0] ^ r_ps_sh[0]) & r_b1);
    assign n_lt1 = (~d1 & r_dur_sh[0]) | (~(d1 ^ r_dur_sh[0]) & r_lt1);
    assign d2    = r_t_sh[0] ^ r_rs_sh[0] ^ r_b2;
    assign n_b2  = (~r_t_sh[0] & r_rs_sh[0]) | (~(r_t_sh[0] ^ r_rs_sh[0]) & r_b2);
    assign n_lt2 = (~d2 & r_thr_sh[0]) | (~(d2 ^ r_thr_sh[0]) & r_lt2);

    assign cur_held  = r_held[r_idx];
    assign cur_fired = r_fired[r_idx];
    assign cur_taps  = r_taps[r_idx];

    always_comb begin
        n_held_b  = cur_held;
        n_fired_b = cur_fired;
        n_taps_b  = cur_taps;
        n_lp      = 1'b0;
        n_dt      = 1'b0;
        case (r_op)
            OP_PRESS: begin
                n_held_b = 1'b1;
                n_taps_b = r_lt2 ? cur_taps + 8'd1 : 8'd1;
            end
            OP_RELEASE: begin
                n_held_b  = 1'b0;
                n_fired_b = 1'b0;
            end
            OP_POLL: begin
                n_lp = cur_held & ~cur_fired & ~r_lt1;
                n_dt = (cur_taps >= TAPS_DOUBLE) & r_lt2;
            end
            OP_ACK: begin
                if (r_ack_long) begin
                    n_fired_b = 1'b1;
                end
                if (r_ack_taps) begin
                    n_taps_b = '0;
                end
            end
            default: begin
                n_held_b = cur_held;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_ok ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control, configuration, per-button flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_long_ms   <= LONG_PRESS_RST;
            r_dtap_ms   <= DOUBLE_TAP_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                r_held[i]   <= 1'b0;
                r_fired[i]  <= 1'b0;
                r_taps[i]   <= '0;
                r_ps_vld[i] <= 1'b0;
                r_rs_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_SHIFT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LONG_PRESS: r_long_ms <= i_cfg_data;
                    REG_DOUBLE_TAP: r_dtap_ms <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit && !r_bad) begin
                r_held[r_idx]  <= n_held_b;
                r_fired[r_idx] <= n_fired_b;
                r_taps[r_idx]  <= n_taps_b;
                if (r_op == OP_PRESS) begin
                    r_ps_vld[r_idx] <= 1'b1;
                end
                if (r_op == OP_RELEASE) begin
                    r_rs_vld[r_idx] <= 1'b1;
                end
            end
        end
    end

    // stamp memories
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ps_rd     <= r_ps_mem[in_idx];
            r_rs_rd     <= r_rs_mem[in_idx];
            r_ps_rd_vld <= r_ps_vld[in_idx];
            r_rs_rd_vld <= r_rs_vld[in_idx];
        end
        if (commit && !r_bad && (r_op == OP_PRESS)) begin
            r_ps_mem[r_idx] <= r_t_sh;
        end
        if (commit && !r_bad && (r_op == OP_RELEASE)) begin
            r_rs_mem[r_idx] <= r_t_sh;
        end
    end

    // transaction payload and serial datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_in.operation;
            r_idx      <= in_idx;
            r_bad      <= !in_ok;
            r_ack_long <= i_in.ack_long;
            r_ack_taps <= i_in.ack_taps;
            r_t_sh     <= i_in.event_time;
            r_dur_sh   <= (i_in.duration_override != '0) ? i_in.duration_override
                                                         : r_long_ms;
            if (i_in.operation == OP_POLL && i_in.window_override != '0) begin
                r_thr_sh <= i_in.window_override;
            end else begin
                r_thr_sh <= r_dtap_ms;
            end
        end
        if (r_state == ST_READ) begin
            r_ps_sh <= r_ps_rd_vld ? r_ps_rd : '0;
            r_rs_sh <= r_rs_rd_vld ? r_rs_rd : '0;
            r_b1    <= 1'b0;
            r_b2    <= 1'b0;
            r_lt1   <= 1'b0;
            r_lt2   <= 1'b0;
        end
        if (r_state == ST_SHIFT) begin
            // event time rotates so it is intact for the stamp write
            r_t_sh   <= {r_t_sh[0], r_t_sh[TIME_W-1:1]};
            r_ps_sh  <= r_ps_sh >> 1;
            r_rs_sh  <= r_rs_sh >> 1;
            r_dur_sh <= r_dur_sh >> 1;
            r_thr_sh <= r_thr_sh >> 1;
            r_b1     <= n_b1;
            r_b2     <= n_b2;
            r_lt1    <= n_lt1;
            r_lt2    <= n_lt2;
        end
        if (commit) begin
            r_out_ok      <= !r_bad;
            r_out_pressed <= !r_bad & n_held_b;
            r_out_lp      <= !r_bad & n_lp;
            r_out_dt      <= !r_bad & n_dt;
            r_out_taps    <= r_bad ? '0 : n_taps_b;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.button_ok  = r_out_ok;
    assign o_out.pressed    = r_out_pressed;
    assign o_out.long_press = r_out_lp;
    assign o_out.double_tap = r_out_dt;
    assign o_out.tap_count  = r_out_taps;

    `BGE_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != ST_IDLE, "ready after accept")
    `BGE_ASSERT_NEXT(a_shift_end, i_clk, i_rst_n, (r_state == ST_SHIFT) && (r_cnt == CNT_LAST), r_state == ST_DONE, "serial pass overran")
    `BGE_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, commit, o_out.valid, "result not presented")
    `BGE_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, o_out.valid && !o_out.button_ok, !o_out.pressed && (o_out.tap_count == '0) && !o_out.long_press && !o_out.double_tap, "out-of-range result nonzero")

endmodule

FILE: tb/bge_gesture_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bge_gesture_checker
// Watches the item and result channels and the register write port of the
// button gesture detector, predicts each result from its own copy of the
// per-button state and the thresholds, and compares every accepted result,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bge_gesture_checker import bge_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bge_in_if                    in_ch,
    bge_out_if                   out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_time                i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic  button_ok;
        logic  pressed;
        logic  long_press;
        logic  double_tap;
        t_taps tap_count;
    } t_gesture_result;

    t_time long_press_cfg;
    t_time double_tap_cfg;
    logic  held_q   [BUTTON_COUNT];
    t_time press_at [BUTTON_COUNT];
    t_time release_at [BUTTON_COUNT];
    t_taps tap_cnt  [BUTTON_COUNT];
    logic  fired_q  [BUTTON_COUNT];

    t_gesture_result expected_gestures [$];
    int              mismatch_count = 0;

    function automatic t_gesture_result gesture_predict(
        t_op op, logic [BTN_FIELD_W-1:0] btn, t_time t, t_time dur_ov, t_time win_ov,
        logic al, logic at);
        t_gesture_result r;
        t_btn_idx        b;
        t_time           dur;
        t_time           win;
        r = '0;
        if (btn >= BUTTON_COUNT)
            return r;
        b = t_btn_idx'(btn);
        case (op)
            OP_PRESS: begin
                held_q[b]   = 1'b1;
                press_at[b] = t;
                if (t_time'(t - release_at[b]) < double_tap_cfg)
                    tap_cnt[b] = tap_cnt[b] + 8'd1;
                else
                    tap_cnt[b] = 8'd1;
            end
            OP_RELEASE: begin
                held_q[b]     = 1'b0;
                release_at[b] = t;
                fired_q[b]    = 1'b0;
            end
            OP_POLL: begin
                dur = (dur_ov != '0) ? dur_ov : long_press_cfg;
                win = (win_ov != '0) ? win_ov : double_tap_cfg;
                r.long_press = held_q[b] && !fired_q[b] && (t_time'(t - press_at[b]) >= dur);
                r.double_tap = (tap_cnt[b] >= TAPS_DOUBLE) &&
                               (t_time'(t - release_at[b]) < win);
            end
            default: begin
                if (al)
                    fired_q[b] = 1'b1;
                if (at)
                    tap_cnt[b] = '0;
            end
        endcase
        r.button_ok = 1'b1;
        r.pressed   = held_q[b];
        r.tap_count = tap_cnt[b];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_gesture_result exp_r;
        if (!i_rst_n) begin
            long_press_cfg = LONG_PRESS_RST;
            double_tap_cfg = DOUBLE_TAP_RST;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                held_q[i]     = 1'b0;
                press_at[i]   = '0;
                release_at[i] = '0;
                tap_cnt[i]    = '0;
                fired_q[i]    = 1'b0;
            end
            expected_gestures.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LONG_PRESS: long_press_cfg = i_cfg_data;
                    REG_DOUBLE_TAP: double_tap_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                expected_gestures.push_back(gesture_predict(in_ch.operation, in_ch.button,
                    in_ch.event_time, in_ch.duration_override, in_ch.window_override,
                    in_ch.ack_long, in_ch.ack_taps));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_gestures.size() == 0) begin
                    $error("result transaction with no item outstanding");
                    mismatch_count++;
                end else begin
                    exp_r = expected_gestures.pop_front();
                    check_field("button_ok", 32'(exp_r.button_ok), 32'(out_ch.button_ok));
                    check_field("pressed", 32'(exp_r.pressed), 32'(out_ch.pressed));
                    check_field("long_press", 32'(exp_r.long_press),
                                32'(out_ch.long_press));
                    check_field("double_tap", 32'(exp_r.double_tap),
                                32'(out_ch.double_tap));
                    check_field("tap_count", 32'(exp_r.tap_count), 32'(out_ch.tap_count));
                end
            end
        end
        o_pending    <= expected_gestures.size();
        o_fail_count <= mismatch_count;
    end

endmodule

FILE: tb/tb_button_gesture_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_gesture_detector_top
// Drives press, release, poll and acknowledge transactions into the gesture
// detector: a directed opening on edge cases, then randomized press/poll/
// release/tap sequences mixed with noise, under several threshold settings,
// with bursty input and a stalling output. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_button_gesture_detector_top;
    import bge_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 140;
    localparam int DRAIN_CYCLES  = 40;
    localparam int TAP_WRAP_RUNS = 260;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_time                i_cfg_data;

    int    fail_count;
    int    gestures_pending;
    int    items_sent  = 0;
    int    burst_left  = 0;
    bit    sender_steady = 1'b0;
    bit    hold_req    = 1'b0;
    t_time now_ms      = '0;

    bge_in_if  in_ch ();
    bge_out_if out_ch ();

    button_gesture_detector_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bge_gesture_checker u_gesture_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (gestures_pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    // result side: stall pattern in segments, plus a one-time long hold-off
    initial begin
        int mode;
        int seg;
        forever begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(50, 300);
            repeat (seg) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    out_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_op op, logic [BTN_FIELD_W-1:0] btn, t_time t, t_time dur,
                             t_time win, logic al, logic at);
        int gap;
        if (!sender_steady && burst_left == 0) begin
            gap = $urandom_range(1, 20);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid             <= 1'b1;
        in_ch.operation         <= op;
        in_ch.button            <= btn;
        in_ch.event_time        <= t;
        in_ch.duration_override <= dur;
        in_ch.window_override   <= win;
        in_ch.ack_long          <= al;
        in_ch.ack_taps          <= at;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (gestures_pending != 0) @(posedge i_clk);
    endtask

    task automatic write_thresholds(t_time lp, t_time dt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_LONG_PRESS;
        i_cfg_data  <= lp;
        @(posedge i_clk);
        i_cfg_index <= REG_DOUBLE_TAP;
        i_cfg_data  <= dt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_time pick_override();
        case ($urandom_range(0, 5))
            3:       return t_time'($urandom_range(1, 1000));
            4:       return t_time'($urandom);
            5:       return '1;
            default: return '0;
        endcase
    endfunction

    function automatic t_time next_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return t_time'($urandom_range(0, 350));
        else if (r < 9)
            return t_time'($urandom_range(0, 1500));
        return t_time'($urandom);
    endfunction

    task automatic run_gesture(logic [BTN_FIELD_W-1:0] btn);
        int polls;
        polls = $urandom_range(0, 3);
        now_ms += next_step();
        send_item(OP_PRESS, btn, now_ms, $urandom, $urandom, 1'($urandom), 1'($urandom));
        repeat (polls) begin
            now_ms += next_step();
            send_item(OP_POLL, btn, now_ms, pick_override(), pick_override(), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 2) == 0) begin
            send_item(OP_ACK, btn, now_ms, $urandom, $urandom, 1'b1, 1'($urandom));
            now_ms += next_step();
            send_item(OP_POLL, btn, now_ms, pick_override(), pick_override(), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 4) == 0) begin
            now_ms += next_step();
            send_item(OP_PRESS, btn, now_ms, $urandom, $urandom, 1'b0, 1'b0);
        end
        now_ms += next_step();
        send_item(OP_RELEASE, btn, now_ms, $urandom, $urandom, 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 9) < 6) begin
            now_ms += t_time'($urandom_range(0, 350));
            send_item(OP_PRESS, btn, now_ms, $urandom, $urandom, 1'b0, 1'b0);
            now_ms += t_time'($urandom_range(0, 200));
            send_item(OP_RELEASE, btn, now_ms, $urandom, $urandom, 1'b0, 1'b0);
            now_ms += t_time'($urandom_range(0, 200));
            send_item(OP_POLL, btn, now_ms, pick_override(), pick_override(), 1'b0, 1'b0);
            if ($urandom_range(0, 1) == 0)
                send_item(OP_ACK, btn, now_ms, $urandom, $urandom, 1'($urandom), 1'b1);
        end
    endtask

    initial begin
        int    phase_goal;
        t_time lp_set;
        t_time dt_set;
        in_ch.valid             <= 1'b0;
        in_ch.operation         <= OP_PRESS;
        in_ch.button            <= '0;
        in_ch.event_time        <= '0;
        in_ch.duration_override <= '0;
        in_ch.window_override   <= '0;
        in_ch.ack_long          <= 1'b0;
        in_ch.ack_taps          <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_index             <= REG_LONG_PRESS;
        i_cfg_data              <= '0;
        i_rst_n                 <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset thresholds
        send_item(OP_POLL,    8'd0,   32'd0,    '0, '0, 1'b0, 1'b0);
        send_item(OP_RELEASE, 8'd3,   32'd100,  '0, '0, 1'b0, 1'b0);
        send_item(OP_PRESS,   8'd3,   32'd200,  '0, '0, 1'b0, 1'b0);
        send_item(OP_PRESS,   8'd3,   32'd250,  '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'd3,   32'd760,  '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'd3,   32'd761,  32'd1, '1, 1'b0, 1'b0);
        send_item(OP_ACK,     8'd3,   32'd770,  '0, '0, 1'b1, 1'b0);
        send_item(OP_POLL,    8'd3,   32'd800,  '0, '0, 1'b0, 1'b0);
        send_item(OP_PRESS,   8'd3,   32'd820,  '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'd3,   32'd1400, '0, '0, 1'b0, 1'b0);
        send_item(OP_RELEASE, 8'd3,   32'd1500, '0, '0, 1'b0, 1'b0);
        send_item(OP_PRESS,   8'd3,   32'd1600, '0, '0, 1'b0, 1'b0);
        send_item(OP_RELEASE, 8'd3,   32'd1650, '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'd3,   32'd1700, '0, '0, 1'b0, 1'b0);
        send_item(OP_ACK,     8'd3,   32'd1710, '0, '0, 1'b0, 1'b1);
        send_item(OP_ACK,     8'd7,   32'd1720, '0, '0, 1'b1, 1'b1);
        send_item(OP_PRESS,   8'd7,   32'd1730, '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'd7,   32'd9000, '0, '0, 1'b0, 1'b0);
        send_item(OP_PRESS,   8'd31,  '1,       '1, '1, 1'b1, 1'b1);
        send_item(OP_POLL,    8'd31,  32'h1F2,  '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'd31,  32'h1F3,  '0, '0, 1'b0, 1'b0);
        send_item(OP_PRESS,   8'd32,  32'd5,    '0, '0, 1'b0, 1'b0);
        send_item(OP_POLL,    8'hFF,  '1,       '1, '1, 1'b1, 1'b1);
        send_item(OP_ACK,     8'h80,  32'd7,    '0, '0, 1'b1, 1'b1);
        send_item(OP_RELEASE, 8'd31,  32'h8000_0000, '0, '0, 1'b0, 1'b0);

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            case (phase)
                0: begin lp_set = LONG_PRESS_RST; dt_set = DOUBLE_TAP_RST; end
                1: begin lp_set = '0; dt_set = '0; end
                2: begin lp_set = '1; dt_set = '1; end
                3: begin
                    lp_set = t_time'($urandom_range(0, 1000));
                    dt_set = t_time'($urandom_range(0, 600));
                end
                4: begin lp_set = t_time'($urandom); dt_set = t_time'($urandom); end
                default: begin lp_set = 32'd1; dt_set = 32'd1; end
            endcase
            write_thresholds(lp_set, dt_set);
            sender_steady = (phase == 2 || phase == 5);
            if (phase == 2) begin
                // window at max: repeated presses run the tap count through its wrap
                for (int k = 0; k < TAP_WRAP_RUNS; k++) begin
                    now_ms += t_time'($urandom_range(1, 3));
                    send_item(OP_PRESS, 8'd9, now_ms, $urandom, $urandom, 1'b0, 1'b0);
                end
                send_item(OP_POLL, 8'd9, now_ms, '0, '0, 1'b0, 1'b0);
                hold_req = 1'b1;
            end
            if (phase == 3)
                now_ms = 32'hFFFF_F000;
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom));
                else if ($urandom_range(0, 3) == 0)
                    run_gesture(8'($urandom_range(0, BUTTON_COUNT - 1)));
                else
                    run_gesture(8'($urandom_range(0, 5)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && gestures_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
